/* hdl/xbm_pkg.sv */
// ----------------------------------------------------------------------------
// xbm_pkg
// Shared types and constants of the XBM text bitmap decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package xbm_pkg;

  typedef enum logic [3:0] {
    M_BETWEEN, M_SLASH, M_COMMENT, M_CSTAR, M_WORD, M_SIGN, M_ZERO,
    M_HEXSTART, M_DIGITS, M_DKEY, M_DGAP1, M_DNAME, M_DGAP2
  } lex_mode_t;

  typedef enum logic [1:0] {
    K_HEADER = 2'd0, K_PIXEL = 2'd1, K_ERROR = 2'd2, K_DONE = 2'd3
  } kind_t;

  localparam logic [2:0] E_EARLY = 3'd0;
  localparam logic [2:0] E_CHAR  = 3'd1;
  localparam logic [2:0] E_WORD  = 3'd2;
  localparam logic [2:0] E_DIR   = 3'd3;
  localparam logic [2:0] E_FILE  = 3'd4;
  localparam logic [2:0] E_SIZE  = 3'd5;

  localparam logic [63:0] KW_STATIC   = 64'h737461746963;
  localparam logic [63:0] KW_UNSIGNED = 64'h756E7369676E6564;
  localparam logic [63:0] KW_CHAR     = 64'h63686172;
  localparam logic [63:0] KW_SHORT    = 64'h73686F7274;
  localparam logic [55:0] SFX_BITS    = 56'h62697473;
  localparam logic [55:0] SFX_WIDTH   = 56'h7769647468;
  localparam logic [55:0] SFX_HEIGHT  = 56'h686569676874;

  // job handed from the front to the back
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  err;
    logic [15:0] bits;
    logic [4:0]  count;
    logic        last;
  } job_t;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
    return d;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5f || c == 8'h24;
  endfunction

endpackage
`default_nettype wire

/* hdl/xbm_text_bitmap_decoder_core.sv */
// ----------------------------------------------------------------------------
// xbm_text_bitmap_decoder_core
// XBM text decoder: characters in, header, pixel, error and done items out.
// ----------------------------------------------------------------------------
//   channel | handshake      | payload
//   in      | push/full      | in_text_char, in_end_of_text
//   out     | empty/pop      | out_kind .. out_last
// A character is accepted, then handled in a lexer step, plus a rescan step
// after a token end and a multiply step for each digit after the first.
// A number emits up to 16 pixels, one per cycle while out is popped.
// full rises while the lexer is busy or the two-entry job queue is full.
// Reset is synchronous and active low; no clearing pass.
`default_nettype none
module xbm_text_bitmap_decoder_core #(
  parameter int DIM_BITS   = 16,
  parameter int NAME_LIMIT = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_text_char,
  input  wire logic        in_end_of_text,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind,
  output logic             out_is_foreground,
  output logic [15:0]      out_image_width,
  output logic [15:0]      out_image_height,
  output logic [2:0]       out_error_code,
  output logic             out_last
);

  xbm_pkg::job_t fj, qj;
  logic fv, qfull, qempty, qrd;
  logic [15:0] fw, fh, qw, qh;

  xbm_front #(.DIM_BITS(DIM_BITS), .NAME_LIMIT(NAME_LIMIT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(push), .in_full(full),
    .in_text_char(in_text_char), .in_end_of_text(in_end_of_text),
    .job_valid(fv), .job(fj), .job_full(qfull), .hdr_width(fw), .hdr_height(fh)
  );

  xbm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(fv), .wdata(fj), .wwidth(fw), .wheight(fh),
    .full(qfull), .rd(qrd), .empty(qempty), .rdata(qj), .rwidth(qw), .rheight(qh)
  );

  xbm_back u_back (
    .clk(clk), .rst_n(rst_n), .job_empty(qempty), .job(qj), .job_width(qw),
    .job_height(qh), .job_rd(qrd), .out_empty(empty), .out_pop(pop),
    .out_kind(out_kind), .out_is_foreground(out_is_foreground),
    .out_image_width(out_image_width), .out_image_height(out_image_height),
    .out_error_code(out_error_code), .out_last(out_last)
  );

endmodule
`default_nettype wire

/* hdl/xbm_front.sv */
// ----------------------------------------------------------------------------
// xbm_front
// Lexer and grammar: takes one character and pushes up to two jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module xbm_front #(
  parameter int DIM_BITS   = 16,
  parameter int NAME_LIMIT = 255
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire logic [7:0]   in_text_char,
  input  wire logic         in_end_of_text,
  output logic              job_valid,
  output xbm_pkg::job_t     job,
  input  wire logic         job_full,
  output logic [15:0]       hdr_width,
  output logic [15:0]       hdr_height
);

  localparam logic [31:0] DIM_MAX = 32'((64'd1 << DIM_BITS) - 64'd1);

  xbm_pkg::lex_mode_t mode_r, mode_nxt;
  logic [31:0] num_r, num_nxt;
  logic [2:0]  bs_r, bs_nxt;
  logic [63:0] head_r, head_nxt;
  logic [55:0] sfx_r, sfx_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [3:0]  gp_r, gp_nxt;
  logic [1:0]  dt_r, dt_nxt;
  logic [DIM_BITS-1:0] sw_r, sw_nxt, rows_r, rows_nxt, col_r, col_nxt;
  logic        short_r, short_nxt;
  logic        stop_r, stop_nxt;
  // character waiting for the lexer, new or retried after a token end
  logic        hold_r, hold_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic        eot_r, eot_nxt;
  // multiply stage for digits
  logic        mul_r, mul_nxt;
  logic [31:0] prod_r;
  logic [3:0]  dig_r;

  logic [7:0]  c;
  logic        busy, again;
  logic [31:0] v, prod_in;
  logic [4:0]  base;
  logic [3:0]  d;
  logic [DIM_BITS-1:0] rem, nbits;
  logic [3:0]  wcode;
  // the rescan of the terminator after a number emits nothing
  logic        tail_quiet;

  assign busy    = hold_r || mul_r;
  assign in_full = busy || job_full;
  assign c       = ch_r;
  assign hdr_width  = 16'(sw_r);
  assign hdr_height = 16'(rows_r);

  always_ff @(posedge clk) begin
    prod_r <= num_r * 32'(base);
    dig_r  <= d;
  end

  function automatic logic [55:0] push_sfx(input logic [55:0] s, input logic [7:0] ch);
    return (ch == 8'h5f) ? 56'd0 : {s[47:0], ch};
  endfunction

  function automatic logic [DIM_BITS-1:0] dimv(input logic [31:0] x);
    return (x >= 32'd1 && x <= DIM_MAX) ? DIM_BITS'(x) : '0;
  endfunction

  always_comb begin
    mode_nxt = mode_r; num_nxt = num_r; bs_nxt = bs_r; head_nxt = head_r;
    sfx_nxt = sfx_r; len_nxt = len_r; gp_nxt = gp_r; dt_nxt = dt_r;
    sw_nxt = sw_r; rows_nxt = rows_r; col_nxt = col_r; short_nxt = short_r;
    stop_nxt = stop_r; hold_nxt = 1'b0; ch_nxt = ch_r; eot_nxt = eot_r;
    mul_nxt = 1'b0;
    job_valid = 1'b0;
    job = '{kind: xbm_pkg::K_PIXEL, err: xbm_pkg::E_EARLY, bits: 16'd0, count: 5'd0,
            last: 1'b1};
    again = 1'b0;
    v = (bs_r[2]) ? 32'd0 - num_r : num_r;
    base = bs_r[1] ? 5'd16 : (bs_r[0] ? 5'd8 : 5'd10);
    d = xbm_pkg::digit_of(c);
    prod_in = prod_r + 32'(dig_r);
    rem = sw_r - col_r;
    nbits = short_r ? DIM_BITS'(16) : DIM_BITS'(8);
    if (nbits > rem) nbits = rem;
    tail_quiet = (c <= 8'd32) || c == "/" || c == "-" || c == "+" ||
                 xbm_pkg::is_ident(c) ||
                 (c == "," && !((col_r + nbits) >= sw_r && rows_r == DIM_BITS'(1)));
    wcode = 4'd0;
    if (len_r == 9'd6 && head_r == xbm_pkg::KW_STATIC) wcode = 4'd1;
    else if (len_r == 9'd8 && head_r == xbm_pkg::KW_UNSIGNED) wcode = 4'd2;
    else if (len_r == 9'd4 && head_r == xbm_pkg::KW_CHAR) wcode = 4'd3;
    else if (len_r == 9'd5 && head_r == xbm_pkg::KW_SHORT) wcode = 4'd4;
    else if (sfx_r == xbm_pkg::SFX_BITS) wcode = 4'd5;

    if (mul_r) begin
      num_nxt = prod_in;
    end else if (in_push && !in_full) begin
      ch_nxt = in_text_char;
      eot_nxt = in_end_of_text;
      hold_nxt = !stop_r;
    end

    if (hold_r && !job_full) begin
      if (eot_r) begin
        job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_EARLY;
        stop_nxt = 1'b1;
      end else begin
        case (mode_r)
          xbm_pkg::M_BETWEEN: begin
            if (c <= 8'd32) begin
            end else if (c == "/") mode_nxt = xbm_pkg::M_SLASH;
            else if (c == "#") begin
              if (gp_r >= 4'd9) begin
                job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_DIR;
              end else begin
                mode_nxt = xbm_pkg::M_DKEY; len_nxt = 9'd0;
              end
            end else if (c == "-" || c == "+" || (c >= "0" && c <= "9")) begin
              num_nxt = 32'd0; bs_nxt = 3'd0;
              if (c == "-" || c == "+") begin
                if (c == "-") bs_nxt = 3'd4;
                mode_nxt = xbm_pkg::M_SIGN;
              end else if (c == "0") mode_nxt = xbm_pkg::M_ZERO;
              else begin
                num_nxt = 32'(c - 8'h30); mode_nxt = xbm_pkg::M_DIGITS;
              end
            end else if (c == "{" || c == "}" || c == ";" || c == "=" || c == "[" ||
                         c == "]" || c == ",") begin
              job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_FILE;
              job_valid = 1'b1;
              if (c == "[" && gp_r == 4'd4) begin gp_nxt = 4'd5; job_valid = 1'b0; end
              else if (c == "]" && (gp_r == 4'd5 || gp_r == 4'd6)) begin
                gp_nxt = 4'd7; job_valid = 1'b0;
              end else if (c == "=" && gp_r == 4'd7) begin
                gp_nxt = 4'd8; job_valid = 1'b0;
              end else if (c == "{" && gp_r == 4'd8) begin
                if (sw_r == '0 || rows_r == '0) job.err = xbm_pkg::E_SIZE;
                else begin
                  job.kind = xbm_pkg::K_HEADER; col_nxt = '0; gp_nxt = 4'd9;
                end
              end else if ((c == "," || c == "}") && gp_r == 4'd10) begin
                job_valid = 1'b0;
                gp_nxt = 4'd9;
                if (col_r >= sw_r) begin
                  col_nxt = '0;
                  rows_nxt = rows_r - DIM_BITS'(1);
                  if (rows_r == DIM_BITS'(1)) begin
                    job_valid = 1'b1; job.kind = xbm_pkg::K_DONE;
                  end
                end
                if (c == "}" && !job_valid) job_valid = 1'b1;
              end
            end else if (xbm_pkg::is_ident(c)) begin
              head_nxt = 64'(c); sfx_nxt = push_sfx(56'd0, c); len_nxt = 9'd1;
              mode_nxt = xbm_pkg::M_WORD;
            end else begin
              job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_CHAR;
            end
          end
          xbm_pkg::M_SLASH: begin
            if (c == "*") mode_nxt = xbm_pkg::M_COMMENT;
            else begin
              job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_CHAR;
            end
          end
          xbm_pkg::M_COMMENT: if (c == "*") mode_nxt = xbm_pkg::M_CSTAR;
          xbm_pkg::M_CSTAR: begin
            if (c == "/") mode_nxt = xbm_pkg::M_BETWEEN;
            else if (c != "*") mode_nxt = xbm_pkg::M_COMMENT;
          end
          xbm_pkg::M_WORD: begin
            if (!xbm_pkg::is_ident(c)) begin
              mode_nxt = xbm_pkg::M_BETWEEN;
              job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_FILE;
              if (wcode == 4'd0) begin job_valid = 1'b1; job.err = xbm_pkg::E_WORD; end
              else if (gp_r <= 4'd2 && (wcode == 4'd3 || wcode == 4'd4)) begin
                short_nxt = wcode == 4'd4; gp_nxt = 4'd3; again = 1'b1;
              end else if (gp_r == 4'd0 && wcode == 4'd1) begin
                gp_nxt = 4'd1; again = 1'b1;
              end else if (gp_r <= 4'd1 && wcode == 4'd2) begin
                gp_nxt = 4'd2; again = 1'b1;
              end else if (gp_r == 4'd3 && wcode == 4'd5) begin
                gp_nxt = 4'd4; again = 1'b1;
              end else job_valid = 1'b1;
            end else if (len_r >= 9'(NAME_LIMIT)) begin
              job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_WORD;
            end else begin
              if (len_r < 9'd8) head_nxt = {head_r[55:0], c};
              sfx_nxt = push_sfx(sfx_r, c); len_nxt = len_r + 9'd1;
            end
          end
          xbm_pkg::M_SIGN: begin
            if (c >= "0" && c <= "9") begin
              if (c == "0") mode_nxt = xbm_pkg::M_ZERO;
              else begin
                num_nxt = 32'(c - 8'h30); mode_nxt = xbm_pkg::M_DIGITS;
              end
            end else begin
              job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR;
              job.err = (dt_r != 2'd0) ? xbm_pkg::E_DIR : xbm_pkg::E_CHAR;
            end
          end
          xbm_pkg::M_ZERO, xbm_pkg::M_HEXSTART, xbm_pkg::M_DIGITS: begin
            if (mode_r == xbm_pkg::M_ZERO && (c == "x" || c == "X")) begin
              bs_nxt = bs_r | 3'd2; mode_nxt = xbm_pkg::M_HEXSTART;
            end else if (mode_r == xbm_pkg::M_ZERO && c >= "0" && c <= "7") begin
              bs_nxt = bs_r | 3'd1; num_nxt = 32'(c - 8'h30); mode_nxt = xbm_pkg::M_DIGITS;
            end else if (mode_r == xbm_pkg::M_HEXSTART && xbm_pkg::is_hex(c)) begin
              num_nxt = 32'(d); mode_nxt = xbm_pkg::M_DIGITS;
            end else if (mode_r == xbm_pkg::M_DIGITS && xbm_pkg::is_hex(c) &&
                         5'(d) < base) begin
              mul_nxt = 1'b1;
            end else begin
              mode_nxt = xbm_pkg::M_BETWEEN;
              again = 1'b1;
              if (dt_r != 2'd0) begin
                if (dt_r == 2'd2) sw_nxt = dimv(v);
                else if (dt_r == 2'd3) rows_nxt = dimv(v);
                dt_nxt = 2'd0;
              end else if (gp_r == 4'd5) gp_nxt = 4'd6;
              else if (gp_r == 4'd9) begin
                if (nbits != '0) begin
                  job_valid = 1'b1; job.kind = xbm_pkg::K_PIXEL;
                  job.bits = v[15:0]; job.count = 5'(nbits);
                  job.last = tail_quiet;
                end
                col_nxt = col_r + nbits; gp_nxt = 4'd10;
              end else begin
                again = 1'b0;
                job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_FILE;
              end
            end
          end
          xbm_pkg::M_DKEY: begin
            if (len_r < 9'd6 && c == 8'("define" >> (8 * (5 - 32'(len_r))))) begin
              len_nxt = len_r + 9'd1;
              if (len_r == 9'd5) mode_nxt = xbm_pkg::M_DGAP1;
            end else begin
              job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_DIR;
            end
          end
          xbm_pkg::M_DGAP1: begin
            if (c > 8'd32) begin
              sfx_nxt = push_sfx(56'd0, c); len_nxt = 9'd1; mode_nxt = xbm_pkg::M_DNAME;
            end
          end
          xbm_pkg::M_DNAME: begin
            if (c <= 8'd32) begin
              dt_nxt = (sfx_r == xbm_pkg::SFX_WIDTH) ? 2'd2 :
                       ((sfx_r == xbm_pkg::SFX_HEIGHT) ? 2'd3 : 2'd1);
              mode_nxt = xbm_pkg::M_DGAP2;
            end else if (len_r >= 9'(NAME_LIMIT)) begin
              job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_DIR;
            end else begin
              sfx_nxt = push_sfx(sfx_r, c); len_nxt = len_r + 9'd1;
            end
          end
          xbm_pkg::M_DGAP2: begin
            if (c <= 8'd32) begin
            end else if (c == "-" || c == "+" || (c >= "0" && c <= "9")) begin
              num_nxt = 32'd0; bs_nxt = 3'd0;
              if (c == "-" || c == "+") begin
                if (c == "-") bs_nxt = 3'd4;
                mode_nxt = xbm_pkg::M_SIGN;
              end else if (c == "0") mode_nxt = xbm_pkg::M_ZERO;
              else begin
                num_nxt = 32'(c - 8'h30); mode_nxt = xbm_pkg::M_DIGITS;
              end
            end else begin
              job_valid = 1'b1; job.kind = xbm_pkg::K_ERROR; job.err = xbm_pkg::E_DIR;
            end
          end
          default: mode_nxt = xbm_pkg::M_BETWEEN;
        endcase
        if (job_valid && (job.kind == xbm_pkg::K_ERROR || job.kind == xbm_pkg::K_DONE))
          stop_nxt = 1'b1;
        if (again && !stop_nxt) hold_nxt = 1'b1;
      end
    end else if (hold_r) begin
      hold_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= xbm_pkg::M_BETWEEN; num_r <= '0; bs_r <= '0; head_r <= '0;
      sfx_r <= '0; len_r <= '0; gp_r <= '0; dt_r <= '0; sw_r <= '0;
      rows_r <= '0; col_r <= '0; short_r <= 1'b0; stop_r <= 1'b0;
      hold_r <= 1'b0; mul_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; num_r <= num_nxt; bs_r <= bs_nxt; head_r <= head_nxt;
      sfx_r <= sfx_nxt; len_r <= len_nxt; gp_r <= gp_nxt; dt_r <= dt_nxt;
      sw_r <= sw_nxt; rows_r <= rows_nxt; col_r <= col_nxt; short_r <= short_nxt;
      stop_r <= stop_nxt; hold_r <= hold_nxt; mul_r <= mul_nxt;
    end
    ch_r  <= ch_nxt;
    eot_r <= eot_nxt;
  end

endmodule
`default_nettype wire

/* hdl/xbm_queue.sv */
// ----------------------------------------------------------------------------
// xbm_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module xbm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr,
  input  wire xbm_pkg::job_t wdata,
  input  wire logic [15:0]   wwidth,
  input  wire logic [15:0]   wheight,
  output logic               full,
  input  wire logic          rd,
  output logic               empty,
  output xbm_pkg::job_t      rdata,
  output logic [15:0]        rwidth,
  output logic [15:0]        rheight
);

  xbm_pkg::job_t mem_r [2];
  logic [15:0] w_r [2];
  logic [15:0] h_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];
  assign rwidth = w_r[rp_r];
  assign rheight = h_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
      w_r[wp_r] <= wwidth;
      h_r[wp_r] <= wheight;
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule
`default_nettype wire

/* hdl/xbm_back.sv */
// ----------------------------------------------------------------------------
// xbm_back
// Expands a job into result items, one per cycle while out is free or popped.
// ----------------------------------------------------------------------------
`default_nettype none
module xbm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_empty,
  input  wire xbm_pkg::job_t job,
  input  wire logic [15:0]   job_width,
  input  wire logic [15:0]   job_height,
  output logic               job_rd,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [1:0]         out_kind,
  output logic               out_is_foreground,
  output logic [15:0]        out_image_width,
  output logic [15:0]        out_image_height,
  output logic [2:0]         out_error_code,
  output logic               out_last
);

  logic       v_r;
  logic [4:0] idx_r, idx_nxt;
  logic       load, fin;

  assign out_empty = !v_r;
  assign load = !job_empty && (!v_r || out_pop);
  assign fin  = (job.kind != xbm_pkg::K_PIXEL) || (idx_r + 5'd1 >= job.count);
  assign job_rd = load && fin;
  assign idx_nxt = fin ? 5'd0 : idx_r + 5'd1;

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind          <= job.kind;
      out_is_foreground <= (job.kind == xbm_pkg::K_PIXEL) ? job.bits[idx_r[3:0]] : 1'b0;
      out_image_width   <= (job.kind == xbm_pkg::K_HEADER) ? job_width : 16'd0;
      out_image_height  <= (job.kind == xbm_pkg::K_HEADER) ? job_height : 16'd0;
      out_error_code    <= (job.kind == xbm_pkg::K_ERROR) ? job.err : 3'd0;
      out_last          <= fin && job.last;
    end
    if (!rst_n) begin
      v_r <= 1'b0; idx_r <= 5'd0;
    end else begin
      if (load) begin
        v_r <= 1'b1; idx_r <= idx_nxt;
      end else if (out_pop) v_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* tb/xbm_text_bitmap_decoder_core_tb.sv */
// ----------------------------------------------------------------------------
// xbm_text_bitmap_decoder_core_tb
// Feeds one complete XBM source file (comments, directives with overrides,
// char or short declaration, data numbers in every radix and sign) through
// the decoder with random gaps on both queues, and checks every output item
// against a cycle-free model of the decoder kept in the testbench.
// ----------------------------------------------------------------------------
`default_nettype none
module xbm_text_bitmap_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } char_item_t;

  typedef struct {
    xbm_pkg::kind_t kind;
    logic        fg;
    logic [15:0] w;
    logic [15:0] h;
    logic [2:0]  err;
    logic        last;
  } decoded_t;

  localparam int RS_RUN = 0, RS_DONE = 1, RS_ERR = 2;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] in_text_char = 8'd0;
  logic in_end_of_text = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] out_kind;
  logic out_is_foreground;
  logic [15:0] out_image_width, out_image_height;
  logic [2:0] out_error_code;
  logic out_last;

  xbm_text_bitmap_decoder_core uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_text_char(in_text_char), .in_end_of_text(in_end_of_text),
    .empty(empty), .pop(pop), .out_kind(out_kind),
    .out_is_foreground(out_is_foreground), .out_image_width(out_image_width),
    .out_image_height(out_image_height), .out_error_code(out_error_code),
    .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_item_t text_q[$];
  decoded_t   decoded_q[$];
  int  phase = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  failed = 1'b0;
  int  quiet_cycles = 0;
  int  step_emits;

  // decoder state
  xbm_pkg::lex_mode_t lmode;
  logic [31:0] num_val;
  logic [2:0]  num_bs;
  logic [63:0] w_head;
  logic [55:0] w_sfx;
  logic [8:0]  w_len;
  int          gpos;
  int          dtgt;
  logic [15:0] st_width, rows_left, col;
  logic        is_short;
  int          run_st;

  function automatic bit ch_space(logic [7:0] c);
    return c <= 8'd32;
  endfunction

  function automatic bit ch_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || ch_digit(c) ||
           c == "_" || c == "$";
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (ch_digit(c)) return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return 99;
  endfunction

  function automatic void emit(xbm_pkg::kind_t k, logic fg, logic [2:0] e);
    decoded_t r;
    if (step_emits >= 17) return;
    r.kind = k;
    r.fg = fg;
    r.w = (k == xbm_pkg::K_HEADER) ? st_width : 16'd0;
    r.h = (k == xbm_pkg::K_HEADER) ? rows_left : 16'd0;
    r.err = e;
    r.last = 1'b0;
    decoded_q.push_back(r);
    step_emits++;
  endfunction

  function automatic void raise_err(logic [2:0] e);
    run_st = RS_ERR;
    emit(xbm_pkg::K_ERROR, 1'b0, e);
  endfunction

  function automatic void sfx_shift(logic [7:0] c);
    w_sfx = (c == "_") ? 56'd0 : {w_sfx[47:0], c};
  endfunction

  function automatic logic [15:0] dim_of(logic [31:0] v);
    return (v >= 1 && v <= 32'hFFFF) ? v[15:0] : 16'd0;
  endfunction

  function automatic void on_word(int code);
    if (gpos <= 2 && (code == 3 || code == 4)) begin
      is_short = (code == 4);
      gpos = 3;
    end else if (gpos == 0 && code == 1) gpos = 1;
    else if (gpos <= 1 && code == 2) gpos = 2;
    else if (gpos == 3 && code == 5) gpos = 4;
    else raise_err(xbm_pkg::E_FILE);
  endfunction

  function automatic void on_number(logic [31:0] v);
    logic [15:0] n, rem;
    if (gpos == 5) begin
      gpos = 6;
      return;
    end
    if (gpos != 9) begin
      raise_err(xbm_pkg::E_FILE);
      return;
    end
    n = is_short ? 16'd16 : 16'd8;
    rem = st_width - col;
    if (n > rem) n = rem;
    for (int j = 0; j < n; j++) emit(xbm_pkg::K_PIXEL, v[j], 3'd0);
    col = col + n;
    gpos = 10;
  endfunction

  function automatic void on_punct(logic [7:0] c);
    if (c == "[" && gpos == 4) gpos = 5;
    else if (c == "]" && (gpos == 5 || gpos == 6)) gpos = 7;
    else if (c == "=" && gpos == 7) gpos = 8;
    else if (c == "{" && gpos == 8) begin
      if (st_width == 0 || rows_left == 0) begin
        raise_err(xbm_pkg::E_SIZE);
        return;
      end
      emit(xbm_pkg::K_HEADER, 1'b0, 3'd0);
      col = 0;
      gpos = 9;
    end else if ((c == "," || c == "}") && gpos == 10) begin
      if (col >= st_width) begin
        col = 0;
        rows_left = rows_left - 1;
        if (rows_left == 0) begin
          run_st = RS_DONE;
          emit(xbm_pkg::K_DONE, 1'b0, 3'd0);
          return;
        end
      end
      if (c == "}") begin
        raise_err(xbm_pkg::E_FILE);
        return;
      end
      gpos = 9;
    end else raise_err(xbm_pkg::E_FILE);
  endfunction

  function automatic void close_number();
    logic [31:0] v;
    v = num_bs[2] ? -num_val : num_val;
    lmode = xbm_pkg::M_BETWEEN;
    if (dtgt != 0) begin
      if (dtgt == 2) st_width = dim_of(v);
      else if (dtgt == 3) rows_left = dim_of(v);
      dtgt = 0;
    end else on_number(v);
  endfunction

  function automatic void open_number(logic [7:0] c);
    num_val = 0;
    num_bs = 0;
    if (c == "-" || c == "+") begin
      if (c == "-") num_bs = 3'd4;
      lmode = xbm_pkg::M_SIGN;
    end else if (c == "0") lmode = xbm_pkg::M_ZERO;
    else begin
      num_val = 32'(c - "0");
      lmode = xbm_pkg::M_DIGITS;
    end
  endfunction

  function automatic void close_word();
    int code;
    code = 0;
    lmode = xbm_pkg::M_BETWEEN;
    if (w_len == 6 && w_head == xbm_pkg::KW_STATIC) code = 1;
    else if (w_len == 8 && w_head == xbm_pkg::KW_UNSIGNED) code = 2;
    else if (w_len == 4 && w_head == xbm_pkg::KW_CHAR) code = 3;
    else if (w_len == 5 && w_head == xbm_pkg::KW_SHORT) code = 4;
    else if (w_sfx == xbm_pkg::SFX_BITS) code = 5;
    if (code == 0) raise_err(xbm_pkg::E_WORD);
    else on_word(code);
  endfunction

  // returns 1 when the character is consumed
  function automatic bit scan_char(logic [7:0] c);
    int d, radix;
    string kw;
    kw = "define";
    case (lmode)
      xbm_pkg::M_BETWEEN: begin
        if (ch_space(c)) return 1;
        if (c == "/") lmode = xbm_pkg::M_SLASH;
        else if (c == "#") begin
          if (gpos >= 9) raise_err(xbm_pkg::E_DIR);
          else begin
            lmode = xbm_pkg::M_DKEY;
            w_len = 0;
          end
        end else if (c == "-" || c == "+" || ch_digit(c)) open_number(c);
        else if (c == "{" || c == "}" || c == ";" || c == "=" || c == "[" ||
                 c == "]" || c == ",") on_punct(c);
        else if (ch_word(c)) begin
          w_head = {56'd0, c};
          w_sfx = 0;
          sfx_shift(c);
          w_len = 1;
          lmode = xbm_pkg::M_WORD;
        end else raise_err(xbm_pkg::E_CHAR);
        return 1;
      end
      xbm_pkg::M_SLASH: begin
        if (c == "*") lmode = xbm_pkg::M_COMMENT;
        else raise_err(xbm_pkg::E_CHAR);
        return 1;
      end
      xbm_pkg::M_COMMENT: begin
        if (c == "*") lmode = xbm_pkg::M_CSTAR;
        return 1;
      end
      xbm_pkg::M_CSTAR: begin
        if (c == "/") lmode = xbm_pkg::M_BETWEEN;
        else if (c != "*") lmode = xbm_pkg::M_COMMENT;
        return 1;
      end
      xbm_pkg::M_WORD: begin
        if (!ch_word(c)) begin
          close_word();
          return 0;
        end
        if (w_len >= 255) begin
          raise_err(xbm_pkg::E_WORD);
          return 1;
        end
        if (w_len < 8) w_head = {w_head[55:0], c};
        sfx_shift(c);
        w_len++;
        return 1;
      end
      xbm_pkg::M_SIGN: begin
        if (ch_digit(c)) begin
          if (c == "0") lmode = xbm_pkg::M_ZERO;
          else begin
            num_val = 32'(c - "0");
            lmode = xbm_pkg::M_DIGITS;
          end
        end else raise_err(dtgt != 0 ? xbm_pkg::E_DIR : xbm_pkg::E_CHAR);
        return 1;
      end
      xbm_pkg::M_ZERO: begin
        if (c == "x" || c == "X") begin
          num_bs[1] = 1'b1;
          lmode = xbm_pkg::M_HEXSTART;
          return 1;
        end
        if (c >= "0" && c <= "7") begin
          num_bs[0] = 1'b1;
          num_val = 32'(c - "0");
          lmode = xbm_pkg::M_DIGITS;
          return 1;
        end
        close_number();
        return 0;
      end
      xbm_pkg::M_HEXSTART: begin
        d = hex_val(c);
        if (d < 16) begin
          num_val = d;
          lmode = xbm_pkg::M_DIGITS;
          return 1;
        end
        close_number();
        return 0;
      end
      xbm_pkg::M_DIGITS: begin
        radix = num_bs[1] ? 16 : (num_bs[0] ? 8 : 10);
        d = hex_val(c);
        if (d < radix) begin
          num_val = num_val * radix + d;
          return 1;
        end
        close_number();
        return 0;
      end
      xbm_pkg::M_DKEY: begin
        if (w_len < 6 && c == kw[w_len]) begin
          w_len++;
          if (w_len == 6) lmode = xbm_pkg::M_DGAP1;
        end else raise_err(xbm_pkg::E_DIR);
        return 1;
      end
      xbm_pkg::M_DGAP1: begin
        if (ch_space(c)) return 1;
        w_sfx = 0;
        sfx_shift(c);
        w_len = 1;
        lmode = xbm_pkg::M_DNAME;
        return 1;
      end
      xbm_pkg::M_DNAME: begin
        if (ch_space(c)) begin
          dtgt = (w_sfx == xbm_pkg::SFX_WIDTH) ? 2 :
                 ((w_sfx == xbm_pkg::SFX_HEIGHT) ? 3 : 1);
          lmode = xbm_pkg::M_DGAP2;
        end else if (w_len >= 255) raise_err(xbm_pkg::E_DIR);
        else begin
          sfx_shift(c);
          w_len++;
        end
        return 1;
      end
      xbm_pkg::M_DGAP2: begin
        if (ch_space(c)) return 1;
        if (c == "-" || c == "+" || ch_digit(c)) open_number(c);
        else raise_err(xbm_pkg::E_DIR);
        return 1;
      end
      default: begin
        lmode = xbm_pkg::M_BETWEEN;
        return 0;
      end
    endcase
  endfunction

  function automatic void decode_char(logic [7:0] c, logic eot);
    int n0;
    n0 = decoded_q.size();
    step_emits = 0;
    if (run_st != RS_RUN) return;
    if (eot) raise_err(xbm_pkg::E_EARLY);
    else begin
      for (int k = 0; k < 4 && run_st == RS_RUN; k++)
        if (scan_char(c)) break;
    end
    if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_text(string s);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.eot = 1'b0;
      text_q.push_back(it);
    end
  endfunction

  function automatic string number_text(logic [31:0] v, bit wide);
    logic [31:0] m;
    m = wide ? {16'd0, v[15:0]} : {24'd0, v[7:0]};
    case ($urandom_range(0, 7))
      0: return $sformatf("0x%0h", m);
      1: return $sformatf("0X%0H", m);
      2: return $sformatf("0%0o", m);
      3: return $sformatf("%0d", m);
      4: return $sformatf("-%0d", m);
      5: return $sformatf("+%0d", m);
      6: return $sformatf("0x%0h", v);
      default: return (m == 0) ? "0" : $sformatf("0x%08h", m);
    endcase
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n && text_q.size() > 0 && (phase == 2 || $urandom_range(0, 99) >=
        (phase == 0 ? 20 : 56))) begin
      push <= 1'b1;
      in_text_char <= text_q[0].ch;
      in_end_of_text <= text_q[0].eot;
    end else begin
      push <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && (phase == 2 || $urandom_range(0, 99) >= (phase == 0 ? 56 : 20));
    end
  end

  // acceptance, checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (push && !full) begin
        decode_char(in_text_char, in_end_of_text);
        void'(text_q.pop_front());
        quiet_cycles = 0;
      end
      if (pop && !empty) begin
        quiet_cycles = 0;
        if (decoded_q.size() == 0) begin
          $error("item with none expected: kind %0d", out_kind);
          failed = 1'b1;
        end else begin
          decoded_t e;
          e = decoded_q.pop_front();
          if (out_kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_kind);
            failed = 1'b1;
          end
          if (out_is_foreground !== e.fg) begin
            $error("is_foreground exp %0d got %0d", e.fg, out_is_foreground);
            failed = 1'b1;
          end
          if (out_image_width !== e.w) begin
            $error("image_width exp %0d got %0d", e.w, out_image_width);
            failed = 1'b1;
          end
          if (out_image_height !== e.h) begin
            $error("image_height exp %0d got %0d", e.h, out_image_height);
            failed = 1'b1;
          end
          if (out_error_code !== e.err) begin
            $error("error_code exp %0d got %0d", e.err, out_error_code);
            failed = 1'b1;
          end
          if (out_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_last);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int wdt, hgt, per_row, wbits, total, n_chars;
    bit wide;
    char_item_t eot_item;
    string decl;
    lmode = xbm_pkg::M_BETWEEN;
    num_val = 0;
    num_bs = 0;
    w_head = 0;
    w_sfx = 0;
    w_len = 0;
    gpos = 0;
    dtgt = 0;
    st_width = 0;
    rows_left = 0;
    col = 0;
    is_short = 0;
    run_st = RS_RUN;

    wide = $urandom_range(0, 1);
    wbits = wide ? 16 : 8;
    wdt = $urandom_range(1, 40);
    per_row = (wdt + wbits - 1) / wbits;
    hgt = 18 / per_row;
    if (hgt < 1) hgt = 1;

    // comment with high-bit characters, directives with rejected values first
    add_text("/* ");
    for (int i = 0; i < 12; i++) begin
      char_item_t it;
      it.ch = 8'($urandom_range(128, 255));
      it.eot = 1'b0;
      text_q.push_back(it);
    end
    add_text("** x */\n#define pic_width 0\n#define pic_height -7\n");
    add_text("#define pic_x_hot 70000\n#define  pic_height 65536\n");
    add_text($sformatf("#define pic_width 0x%0h\n#define pic_height 0%0o\n", wdt, hgt));
    case ($urandom_range(0, 3))
      0: decl = "static unsigned ";
      1: decl = "static ";
      2: decl = "unsigned ";
      default: decl = "";
    endcase
    decl = {decl, wide ? "short" : "char", " pic_bits[",
            ($urandom_range(0, 1) ? "" : "99"), "] = {\n"};
    add_text(decl);

    total = per_row * hgt;
    for (int i = 0; i < total; i++) begin
      logic [31:0] v;
      v = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd0 : $urandom;
      if (i == 2) add_text("0x");
      else add_text(number_text(v, wide));
      if (i == total - 1) add_text("};\n");
      else if ($urandom_range(0, 3) == 0) add_text(" /*c*/ ,\n ");
      else add_text(", ");
    end
    eot_item.ch = 8'h7f;
    eot_item.eot = 1'b1;
    text_q.push_back(eot_item);
    n_chars = text_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() > (n_chars * 2) / 3) @(posedge clk);
    phase = 1;
    while (text_q.size() > n_chars / 3) @(posedge clk);
    phase = 2;
    hold_req = 1'b1;
    while (text_q.size() > 0 || decoded_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed && decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
hdl/xbm_pkg.sv
hdl/xbm_front.sv
hdl/xbm_queue.sv
hdl/xbm_back.sv
hdl/xbm_text_bitmap_decoder_core.sv
tb/xbm_text_bitmap_decoder_core_tb.sv
